// File: hw/rtl/amru_pkg.sv
package amru_pkg;

  // Memory geometry: a power-of-two number of 64-bit words.
  localparam int MEM_WORDS = 1024;
  localparam int WORD_AW   = $clog2(MEM_WORDS);

  typedef logic [WORD_AW-1:0] word_addr_t;

  // Operation codes.
  typedef logic [3:0] func_t;
  localparam func_t FN_SWAP   = 4'd0;
  localparam func_t FN_ADD    = 4'd1;
  localparam func_t FN_SUB    = 4'd2;
  localparam func_t FN_AND    = 4'd3;
  localparam func_t FN_OR     = 4'd4;
  localparam func_t FN_XOR    = 4'd5;
  localparam func_t FN_ANDNOT = 4'd6;
  localparam func_t FN_NEG    = 4'd7;
  localparam func_t FN_CAS    = 4'd8;

  // Completion status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_BAD_SIZE = 2'd1;
  localparam status_t ST_BAD_FUNC = 2'd2;

  // One request to the data memory: two reads and one write per cycle.
  typedef struct packed {
    logic        re;
    word_addr_t  raddr_lo;
    word_addr_t  raddr_hi;
    logic        we;
    word_addr_t  waddr;
    logic [63:0] wdata;
  } mem_req_t;

  // Byte mask of an operand of the given size; invalid sizes never use it.
  function automatic logic [63:0] size_mask(input logic [3:0] size);
    logic [63:0] m;
    case (size)
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/amru_mem.sv
module amru_mem (
  input  logic               clk,
  input  amru_pkg::mem_req_t req,
  output logic [63:0]        rd_lo,
  output logic [63:0]        rd_hi
);
  import amru_pkg::*;

  logic [63:0] mem [MEM_WORDS];
  logic [63:0] rd_lo_r;
  logic [63:0] rd_hi_r;

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_lo_r <= mem[req.raddr_lo];
      rd_hi_r <= mem[req.raddr_hi];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule

// File: hw/rtl/amru_alu.sv
module amru_alu (
  input  amru_pkg::func_t func,
  input  logic [63:0]     old_value,
  input  logic [63:0]     operand,
  input  logic [63:0]     expected_value,
  input  logic [63:0]     mask,
  output logic [63:0]     new_value,
  output logic            store
);
  import amru_pkg::*;

  logic [63:0] opnd;
  logic [63:0] expv;
  logic [63:0] res;

  assign opnd = operand & mask;
  assign expv = expected_value & mask;

  // New value of the operation; compare-and-swap stores only on a match.
  always_comb begin
    store = 1'b1;
    case (func)
      FN_SWAP:   res = opnd;
      FN_ADD:    res = old_value + opnd;
      FN_SUB:    res = old_value - opnd;
      FN_AND:    res = old_value & opnd;
      FN_OR:     res = old_value | opnd;
      FN_XOR:    res = old_value ^ opnd;
      FN_ANDNOT: res = old_value & ~opnd;
      FN_NEG:    res = 64'd0 - old_value;
      default: begin
        res   = opnd;
        store = (old_value == expv);
      end
    endcase
  end

  assign new_value = res & mask;

endmodule

// File: hw/rtl/misaligned_atomic_rmw_unit.sv
// Atomic read-modify-write unit on a little-endian byte memory of 64-bit words.
// The input channel (in_valid/in_ready) carries one word per operation: func,
// byte address (any alignment, wraps at the end of memory), size and operands.
// The result channel (out_valid/out_ready) returns one word per operation: the
// old value masked to size and a status (done, bad size, unknown operation).
// Operations run one at a time through a read, a modify and a write-back:
// the old value is registered in S_RD and goes to the output register in S_OUT;
// the next word is taken after write-back, in S_WR0 when nothing or one word
// is stored, in S_WR0 and S_WR1 when an access straddles two words and stores
// both. Both words are read together over the two read ports; the single write
// port sets the straddle cost. After reset the unit clears the memory one word
// per cycle, all MEM_WORDS (1024) words, and holds in_ready low until that pass
// is done. A stalled receiver holds the result in the output register; the unit
// then waits before write-back, so a new word is accepted only once the stalled
// result has been taken and the pending one has moved into the output register.
module misaligned_atomic_rmw_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  amru_pkg::func_t     in_func,
  input  logic [12:0]         in_byte_address,
  input  logic [3:0]          in_size_bytes,
  input  logic [63:0]         in_operand,
  input  logic [63:0]         in_expected_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_old_value,
  output amru_pkg::status_t   out_status
);
  import amru_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_OUT, S_WR0, S_WR1} state_t;

  state_t      state_r;
  word_addr_t  clr_r;
  func_t       func_r;
  logic [2:0]  off_r;
  logic [63:0] mask_r;
  logic [63:0] opnd_r;
  logic [63:0] expv_r;
  logic        err_r;
  status_t     stat_r;
  logic        straddle_r;
  word_addr_t  w0_r;
  word_addr_t  w1_r;
  logic [63:0] lo_r;
  logic [63:0] hi_r;
  logic [63:0] old_r;
  logic [63:0] mrg_lo_r;
  logic [63:0] mrg_hi_r;
  logic        store_r;
  logic        out_valid_r;
  logic [63:0] out_old_r;
  status_t     out_stat_r;

  mem_req_t    mem_req;
  logic [63:0] rd_lo;
  logic [63:0] rd_hi;
  logic [63:0] alu_new;
  logic        alu_store;

  word_addr_t  in_w0;
  word_addr_t  in_w1;
  logic        in_size_ok;
  logic        in_acc;
  logic        out_free;
  logic [127:0] rd_pair;
  logic [127:0] rd_shift;
  logic [6:0]   sh;
  logic [127:0] wmask;
  logic [127:0] wnew;
  logic [127:0] merged;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Word indexes of the access; the second word wraps past the end.
  assign in_w0 = in_byte_address[3 +: WORD_AW];
  assign in_w1 = (in_w0 == word_addr_t'(MEM_WORDS - 1)) ? '0 : in_w0 + 1'b1;
  assign in_size_ok = (in_size_bytes == 4'd1) || (in_size_bytes == 4'd2) ||
                      (in_size_bytes == 4'd4) || (in_size_bytes == 4'd8);

  // Old value: both words side by side, shifted down to the first byte.
  assign sh       = {1'b0, off_r, 3'b000};
  assign rd_pair  = {rd_hi, rd_lo};
  assign rd_shift = rd_pair >> sh;

  amru_alu u_alu (
    .func           (func_r),
    .old_value      (old_r),
    .operand        (opnd_r),
    .expected_value (expv_r),
    .mask           (mask_r),
    .new_value      (alu_new),
    .store          (alu_store)
  );

  // Merge the new bytes into the two words that were read.
  assign wmask  = {64'd0, mask_r} << sh;
  assign wnew   = {64'd0, alu_new} << sh;
  assign merged = ({hi_r, lo_r} & ~wmask) | wnew;

  // Memory request: clearing pass, reads at acceptance, write-back.
  always_comb begin
    mem_req          = '0;
    mem_req.re       = in_acc;
    mem_req.raddr_lo = in_w0;
    mem_req.raddr_hi = in_w1;
    mem_req.waddr    = w0_r;
    mem_req.wdata    = mrg_lo_r;
    unique case (state_r)
      S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
      end
      S_WR0: mem_req.we = store_r;
      S_WR1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = w1_r;
        mem_req.wdata = mrg_hi_r;
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  amru_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register empties unless a new result is loaded this cycle.
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == word_addr_t'(MEM_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r     <= in_func;
            off_r      <= in_byte_address[2:0];
            mask_r     <= size_mask(in_size_bytes);
            opnd_r     <= in_operand;
            expv_r     <= in_expected_value;
            w0_r       <= in_w0;
            w1_r       <= in_w1;
            straddle_r <= ({2'b00, in_byte_address[2:0]} + {1'b0, in_size_bytes}) > 5'd8;
            if (!in_size_ok) begin
              err_r  <= 1'b1;
              stat_r <= ST_BAD_SIZE;
            end else if (in_func > FN_CAS) begin
              err_r  <= 1'b1;
              stat_r <= ST_BAD_FUNC;
            end else begin
              err_r  <= 1'b0;
              stat_r <= ST_DONE;
            end
            state_r <= S_RD;
          end
        end
        S_RD: begin
          lo_r    <= rd_lo;
          hi_r    <= rd_hi;
          old_r   <= err_r ? 64'd0 : (rd_shift[63:0] & mask_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_old_r   <= old_r;
            out_stat_r  <= stat_r;
            mrg_lo_r    <= merged[63:0];
            mrg_hi_r    <= merged[127:64];
            store_r     <= alu_store && !err_r;
            state_r     <= S_WR0;
          end
        end
        S_WR0: begin
          state_r <= (store_r && straddle_r) ? S_WR1 : S_IDLE;
        end
        S_WR1: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_old_value = out_old_r;
  assign out_status    = out_stat_r;

  // A rejected operation never writes memory.
  a_err_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR0 && err_r) |-> !mem_req.we)
    else $error("rejected operation writes memory");

  // The second word is written only for a straddling store, at the next word.
  a_hi_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |-> (store_r && straddle_r && mem_req.waddr == w1_r))
    else $error("second-word write without a straddling store");

  // An accepted word, with the output register empty at acceptance, passes
  // through S_RD and S_OUT and then loads its result into the output register.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_valid_r) |=> ##1 (state_r == S_OUT) ##1 out_valid_r)
    else $error("accepted word did not produce a result");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import amru_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LONG_HOLD   = 250;
  localparam int HOLD_AT     = 300;
  localparam int TAIL_CYCLES = 20;

  // One input word and the reply it should produce.
  typedef struct {
    func_t       func;
    logic [12:0] addr;
    logic [3:0]  size;
    logic [63:0] operand;
    logic [63:0] expv;
    bit          drain_first;
  } rmw_word_t;

  typedef struct {
    logic [63:0] old_value;
    status_t     status;
  } rmw_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  func_t       in_func = FN_SWAP;
  logic [12:0] in_byte_address = '0;
  logic [3:0]  in_size_bytes = '0;
  logic [63:0] in_operand = '0;
  logic [63:0] in_expected_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_old_value;
  status_t     out_status;

  // Shadow copy of the data memory, cleared like the block's after reset.
  logic [63:0] mem_image [MEM_WORDS];

  rmw_word_t   pending[$];
  rmw_reply_t  rmw_replies[$];
  rmw_word_t   cur;
  rmw_reply_t  want;
  int          n_predicted = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          gap_left = 0;
  int          rx_wait = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  int          outstanding;
  bit          took;

  misaligned_atomic_rmw_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_byte_address   (in_byte_address),
    .in_size_bytes     (in_size_bytes),
    .in_operand        (in_operand),
    .in_expected_value (in_expected_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_old_value     (out_old_value),
    .out_status        (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Performs the read-modify-write on the shadow memory and returns the reply.
  function automatic rmw_reply_t apply_rmw(input rmw_word_t w);
    rmw_reply_t  r;
    logic [63:0] mask;
    logic [63:0] opnd;
    logic [63:0] old_v;
    logic [63:0] new_v;
    bit          store;
    bit          size_ok;
    int unsigned a;
    int unsigned sh;
    r.old_value = '0;
    r.status = ST_DONE;
    case (w.size)
      4'd1, 4'd2, 4'd4, 4'd8: size_ok = 1'b1;
      default:                size_ok = 1'b0;
    endcase
    if (!size_ok) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    if (w.func > FN_CAS) begin
      r.status = ST_BAD_FUNC;
      return r;
    end
    mask = (w.size == 4'd8) ? '1 : ((64'd1 << (8 * w.size)) - 64'd1);
    opnd = w.operand & mask;
    old_v = '0;
    // Gather the old bytes little-endian, wrapping at the end of memory.
    for (int i = 0; i < w.size; i++) begin
      a = (w.addr + i) % (MEM_WORDS * 8);
      sh = (a % 8) * 8;
      old_v |= ((mem_image[a / 8] >> sh) & 64'hFF) << (8 * i);
    end
    store = 1'b1;
    case (w.func)
      FN_SWAP:   new_v = opnd;
      FN_ADD:    new_v = old_v + opnd;
      FN_SUB:    new_v = old_v - opnd;
      FN_AND:    new_v = old_v & opnd;
      FN_OR:     new_v = old_v | opnd;
      FN_XOR:    new_v = old_v ^ opnd;
      FN_ANDNOT: new_v = old_v & ~opnd;
      FN_NEG:    new_v = 64'd0 - old_v;
      default: begin
        new_v = opnd;
        store = (old_v == (w.expv & mask));
      end
    endcase
    new_v &= mask;
    if (store) begin
      for (int i = 0; i < w.size; i++) begin
        a = (w.addr + i) % (MEM_WORDS * 8);
        sh = (a % 8) * 8;
        mem_image[a / 8] = (mem_image[a / 8] & ~(64'hFF << sh)) |
                           (((new_v >> (8 * i)) & 64'hFF) << sh);
      end
    end
    r.old_value = old_v;
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 40) return 64'($urandom_range(0, 255));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] pick_size();
    if ($urandom_range(0, 99) < 12) return 4'($urandom_range(0, 15));
    return 4'd1 << $urandom_range(0, 3);
  endfunction

  task automatic queue_word(input func_t f, input logic [12:0] a, input logic [3:0] s,
                            input logic [63:0] op, input logic [63:0] ev);
    rmw_word_t w;
    w.func = f;
    w.addr = a;
    w.size = s;
    w.operand = op;
    w.expv = ev;
    w.drain_first = 1'b0;
    pending.push_back(w);
  endtask

  // Stimulus: directed corner cases, then random words and swap/cas pairs.
  initial begin
    logic [12:0] win_base;
    logic [12:0] a;
    logic [3:0]  s;
    logic [63:0] v;
    int          n_rand;
    foreach (mem_image[i]) mem_image[i] = '0;

    queue_word(FN_SWAP,   13'd0,    4'd8, 64'h0123_4567_89AB_CDEF, '0);
    queue_word(FN_ADD,    13'd3,    4'd4, 64'hFFFF_FFFF, '0);
    queue_word(FN_SUB,    13'd6,    4'd4, 64'h1234_5678, '1);
    queue_word(FN_AND,    13'd1,    4'd2, 64'hF0F0, '0);
    queue_word(FN_OR,     13'd7,    4'd2, 64'h8001, '0);
    queue_word(FN_XOR,    13'd2,    4'd8, '1, '0);
    queue_word(FN_ANDNOT, 13'd4,    4'd8, 64'h00FF_00FF_00FF_00FF, '0);
    queue_word(FN_NEG,    13'd0,    4'd1, '0, '0);
    queue_word(FN_NEG,    13'd8,    4'd8, '1, '0);
    queue_word(FN_CAS,    13'd0,    4'd8, 64'hDEAD_BEEF, '0);
    queue_word(FN_SWAP,   13'h1FFF, 4'd8, 64'hA5A5_5A5A_C3C3_3C3C, '0);
    queue_word(FN_CAS,    13'h1FFF, 4'd8, '1, 64'hA5A5_5A5A_C3C3_3C3C);
    queue_word(FN_SWAP,   13'h1FFE, 4'd2, 64'hFFFF, '0);
    queue_word(FN_ADD,    13'h1FFC, 4'd4, 64'd1, '0);
    queue_word(FN_SWAP,   13'h1FF8, 4'd8, '1, '0);
    queue_word(FN_SWAP,   13'd16,   4'd1, '1, '0);
    queue_word(FN_CAS,    13'd16,   4'd1, 64'h12, '1);
    queue_word(FN_SWAP,   13'd24,   4'd0, '1, '0);
    queue_word(FN_CAS,    13'd24,   4'd3, '1, '0);
    queue_word(func_t'(4'd15), 13'd24, 4'd15, '1, '1);
    queue_word(FN_ADD,    13'd24,   4'd9, '1, '0);
    queue_word(func_t'(4'd9),  13'd32, 4'd4, '1, '0);
    queue_word(func_t'(4'd15), 13'h1FFF, 4'd8, '1, '1);
    queue_word(FN_ADD,    13'd0,    4'd8, '0, '0);
    queue_word(FN_SWAP,   13'd4096, 4'd4, '0, '0);

    // The random part starts from an empty pipeline when its first item is a single word.
    n_rand = 0;
    win_base = 13'($urandom_range(0, 8191));
    while (n_rand < RANDOM_ITEMS) begin
      if (n_rand % 64 == 0)
        win_base = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(8150, 8191))
                                               : 13'($urandom_range(0, 8191));
      a = ($urandom_range(0, 99) < 60) ? win_base + 13'($urandom_range(0, 47))
                                       : 13'($urandom_range(0, 8191));
      s = pick_size();
      if ($urandom_range(0, 99) < 20) begin
        // Store a known value, then compare-and-swap against it or a random value.
        v = pick_value();
        queue_word(FN_SWAP, a, s, v, pick_value());
        queue_word(FN_CAS, a, s, pick_value(),
                   ($urandom_range(0, 3) == 0) ? pick_value() : v);
        n_rand += 2;
      end else begin
        queue_word(($urandom_range(0, 99) < 92) ? func_t'($urandom_range(0, 8))
                                                : func_t'($urandom_range(0, 15)),
                   a, s, pick_value(), pick_value());
        n_rand++;
      end
      if (n_rand == 1 || (n_rand >= 900 && n_rand <= 901))
        pending[pending.size() - 1].drain_first = 1'b1;
    end

    wait (rst_n);
    @(negedge clk);
    while (pending.size() != 0 || in_valid || n_checked != n_predicted) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Sender: offers one word at a time, with random gaps or, in some phases, none.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        rmw_replies.push_back(apply_rmw(cur));
        n_predicted <= n_predicted + 1;
        n_sent++;
        gap_left = ((n_sent / 200) % 4 == 3) ? 0 : $urandom_range(0, 9);
      end
      outstanding = n_predicted + int'(took) - n_checked;
      if (in_valid && !took) begin
        // Hold the word until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0 && (!pending[0].drain_first || outstanding == 0)) begin
        cur = pending.pop_front();
        in_func <= cur.func;
        in_byte_address <= cur.addr;
        in_size_bytes <= cur.size;
        in_operand <= cur.operand;
        in_expected_value <= cur.expv;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each reply against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (n_checked >= n_predicted) begin
          $display("%0t: reply with nothing outstanding: old_value %h status %0d",
                   $time, out_old_value, out_status);
          error_count++;
        end else begin
          want = rmw_replies[n_checked];
          if (out_old_value !== want.old_value) begin
            $display("%0t: old_value mismatch on word %0d: expected %h, actual %h",
                     $time, n_checked, want.old_value, out_old_value);
            error_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch on word %0d: expected %0d, actual %0d",
                     $time, n_checked, want.status, out_status);
            error_count++;
          end
          n_checked <= n_checked + 1;
        end
        rx_wait = ((n_checked / 170) % 4 == 2) ? 0 : $urandom_range(0, 9);
        // Once, stop taking replies long enough for the block to back up.
        if (n_checked == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
